>>> hw/rtl/dib_pkg.sv
`timescale 1ns / 1ps
// dib_pkg: shared constants, types and the filter step function for the
// debounced input bank. Used by dib_div and debounced_input_bank_top.
package dib_pkg;

	localparam int SLOTS      = 4;                   // channel bits in every field
	localparam int FILT_SHIFT = 22;                  // fixed-point scale of alpha
	localparam int ALPHA_W    = FILT_SHIFT + 1;      // alpha <= 2^22
	localparam int DIVISOR_W  = 9;                   // tau + 1 <= 256
	localparam int DIV_STEPS  = 12;                  // two quotient bits a step
	localparam int DIV_CNT_W  = 4;
	localparam int PROD_W     = ALPHA_W + 8;         // alpha * |target - level|
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 24;
	localparam int CHANNELS_DEF = 4;

	localparam logic [CFG_DATA_W-1:0] TAU_RST   = 32'h3232_3232;
	localparam logic [7:0]            THR_H_RST = 8'd192;
	localparam logic [7:0]            THR_L_RST = 8'd64;
	localparam logic [SLOTS-1:0]      LED_RST   = 4'hF;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_TAU   = 2'd0,
		REG_THR_H = 2'd1,
		REG_THR_L = 2'd2,
		REG_LED   = 2'd3
	} reg_idx_t;

	// one filter step: level moves toward 255 (up) or 0 by the scaled product,
	// rounded toward zero around the midpoint 128 as the fixed-point form does
	function automatic logic [7:0] filt_next(input logic [7:0] lvl, input logic up,
			input logic [PROD_W-1:0] prod);
		logic [7:0]  mag;
		logic [8:0]  p;
		logic        frac;
		logic [8:0]  gap;
		logic        ext;
		logic [9:0]  step;
		logic [9:0]  sum;
		logic [7:0]  res;
		mag  = up ? (8'd255 - lvl) : lvl;
		p    = prod[PROD_W-1:FILT_SHIFT];
		frac = |prod[FILT_SHIFT-1:0];
		if (p == 9'd0) begin
			// minimum step of one whole unit
			p    = 9'd1;
			frac = 1'b0;
		end
		if (up) begin
			gap = 9'd128 - {1'b0, lvl};
			ext = frac && !lvl[7] && (p < gap);
		end else begin
			gap = {1'b0, lvl} - 9'd128;
			ext = frac && lvl[7] && (p < gap);
		end
		step = {1'b0, p} + {9'd0, ext};
		if (mag == 8'd0) begin
			res = lvl;
		end else if (up) begin
			sum = {2'b00, lvl} + step;
			res = (sum > 10'd255) ? 8'd255 : sum[7:0];
		end else begin
			res = (step > {2'b00, lvl}) ? 8'd0 : 8'(({2'b00, lvl} - step));
		end
		return res;
	endfunction

endpackage

>>> hw/rtl/dib_div.sv
`timescale 1ns / 1ps
// dib_div: iterative radix-4 divider computing alpha = 2^22 / divisor.
// Depends on dib_pkg for widths and step count.
module dib_div
	import dib_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic                 done,
	output logic [ALPHA_W-1:0]   quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [2*DIV_STEPS-1:0] quo_q;

	logic [DIVISOR_W:0]   r1, r2;
	logic [DIVISOR_W-1:0] r1s, r2s;
	logic                 ge1, ge2, b0;

	// dividend is a single one at bit 22: only the low bit of the first pair
	assign b0 = (cnt_q == '0);

	always_comb begin
		r1  = {rem_q, 1'b0};
		ge1 = (r1 >= {1'b0, divisor});
		r1s = ge1 ? DIVISOR_W'(r1 - {1'b0, divisor}) : r1[DIVISOR_W-1:0];
		r2  = {r1s, b0};
		ge2 = (r2 >= {1'b0, divisor});
		r2s = ge2 ? DIVISOR_W'(r2 - {1'b0, divisor}) : r2[DIVISOR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= r2s;
			quo_q <= {quo_q[2*DIV_STEPS-3:0], ge1, ge2};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[ALPHA_W-1:0];

endmodule

>>> hw/rtl/debounced_input_bank_top.sv
`timescale 1ns / 1ps
// debounced_input_bank_top: per-channel filter, hysteresis and edge masks
// for a bank of raw inputs. Depends on dib_pkg and dib_div.
//
//  channel  | direction | payload
//  s_*      | in        | tdata[3:0] raw_levels
//  m_*      | out       | tdata stable, rise, fall, any, raw echo, led levels
//  cfg_*    | in        | write enable, register index, write data
//
// each channel of an item starts the shared divider, which runs its 12
// radix-4 steps for alpha and signals done; then come the multiply (ST_MUL)
// and the update (ST_FIN). after the last channel the result loads the output
// register, and only then is a new item accepted. s_tready is high only while
// no item is in work. a finished result sits in the output register; the next
// item is accepted meanwhile, and its result waits until that register is taken.
// reset clears levels and stable bits and loads the register defaults.
module debounced_input_bank_top
	import dib_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [3:0] raw_levels
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [3:0] stable_states, [7:4] edges_rise,
	                                         // [11:8] edges_fall, [15:12] edges_any,
	                                         // [19:16] raw_echo, [23:20] led_levels
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [SLOTS-1:0] CH_MASK = SLOTS'((1 << CHANNELS) - 1);

	typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_MUL, ST_FIN, ST_OUT} state_t;

	state_t                state_q;
	logic [CH_W-1:0]       ch_q;
	logic                  start_q;
	logic [SLOTS-1:0]      raw_q;
	logic [CHANNELS-1:0]   old_q;
	logic [CHANNELS-1:0]   stable_q;
	logic [7:0]            level_q [CHANNELS];
	logic [PROD_W-1:0]     prod_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [CFG_DATA_W-1:0] tau_q;
	logic [7:0]            thr_h_q;
	logic [7:0]            thr_l_q;
	logic [SLOTS-1:0]      led_q;

	logic                  div_done;
	logic [ALPHA_W-1:0]    alpha;
	logic [7:0]            tau_cur;
	logic [7:0]            lvl_cur;
	logic                  up_cur;
	logic [7:0]            mag_cur;
	logic [7:0]            lvl_new;
	logic                  st_prev, st_next;
	logic [SLOTS-1:0]      new4, old4;
	logic                  out_load;

	assign tau_cur = tau_q[ch_q*8 +: 8];
	assign lvl_cur = level_q[ch_q];
	assign up_cur  = raw_q[ch_q];
	assign mag_cur = up_cur ? (8'd255 - lvl_cur) : lvl_cur;
	assign lvl_new = filt_next(lvl_cur, up_cur, prod_q);
	assign st_prev = stable_q[ch_q];

	// result moves into the output register once that register is free
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// hysteresis: each bit tested only against the rule for its own value
	always_comb begin
		st_next = st_prev;
		if (!st_prev && (lvl_new >= thr_h_q))
			st_next = 1'b1;
		else if (st_prev && (lvl_new <= thr_l_q))
			st_next = 1'b0;
	end

	assign new4 = SLOTS'(stable_q);
	assign old4 = SLOTS'(old_q);

	dib_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.divisor  ({1'b0, tau_cur} + 9'd1),
		.done     (div_done),
		.quotient (alpha)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tau_q   <= TAU_RST;
			thr_h_q <= THR_H_RST;
			thr_l_q <= THR_L_RST;
			led_q   <= LED_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_TAU:   tau_q   <= cfg_wdata;
				REG_THR_H: thr_h_q <= cfg_wdata[7:0];
				REG_THR_L: thr_l_q <= cfg_wdata[7:0];
				REG_LED:   led_q   <= cfg_wdata[SLOTS-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ch_q       <= '0;
			start_q    <= 1'b0;
			raw_q      <= '0;
			old_q      <= '0;
			stable_q   <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++)
				level_q[i] <= '0;
		end else begin
			start_q <= 1'b0;
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						raw_q   <= s_tdata[SLOTS-1:0] & CH_MASK;
						old_q   <= stable_q;
						ch_q    <= '0;
						start_q <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					level_q[ch_q]  <= lvl_new;
					stable_q[ch_q] <= st_next;
					if (ch_q == CH_W'(CHANNELS - 1)) begin
						state_q <= ST_OUT;
					end else begin
						ch_q    <= ch_q + 1'b1;
						start_q <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_OUT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL)
			prod_q <= {8'd0, alpha} * {{(ALPHA_W){1'b0}}, mag_cur};
		if (out_load)
			m_tdata_q <= {(new4 ^ led_q) & CH_MASK, raw_q, old4 ^ new4,
				old4 & ~new4, ~old4 & new4, new4};
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// no new item is taken in the cycle after one is accepted
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is in work");

	// divider finishes only while the sequencer waits for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider result outside the divide phase");

	// edge masks stay consistent with each other
	a_edge_union: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[15:12] == (m_tdata[7:4] | m_tdata[11:8]))
			&& ((m_tdata[7:4] & m_tdata[11:8]) == 4'd0)))
		else $error("edge masks inconsistent");

endmodule
